// ----- rtl/itct_pkg.sv -----
// Package for the isochronous transmit credit tracker.
// Holds table sizes, command and status codes, sequencer states and shared types.
// No dependencies; every other file of the block uses it by scoped names.
package itct_pkg;

   // Table geometry.
   localparam int MAX_LINKS = 16;
   localparam int IDX_W     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;

   // Field widths.
   localparam int HANDLE_W = 12;
   localparam int CREDIT_W = 16;
   localparam int LEN_W    = 16;
   localparam int HDR_W    = 32;

   // Limits on a send command.
   localparam logic [LEN_W-1:0]    MAX_LOAD     = 16'd16383;
   localparam logic [HANDLE_W-1:0] HANDLE_LIMIT = 12'h0EFF;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_REGISTER   = 2'd0,
      CMD_DEREGISTER = 2'd1,
      CMD_SEND       = 2'd2,
      CMD_COMPLETE   = 2'd3
   } cmd_type;

   // Result status codes.
   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_PARAM = 2'd1,
      STAT_NO_CREDIT = 2'd2,
      STAT_NO_ENTRY  = 2'd3
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_CREDIT,
      S_COUNT
   } state_type;

   // Operations of the shared arithmetic unit.
   typedef enum logic [1:0] {
      ALU_ADD_CLAMP,
      ALU_SUB_SAT,
      ALU_INC_SAT
   } alu_op_type;

   // One request to the arithmetic unit.
   typedef struct packed {
      alu_op_type          op;
      logic [CREDIT_W-1:0] a;
      logic [CREDIT_W-1:0] b;
      logic [CREDIT_W-1:0] limit;
   } alu_req_type;

   // What the table scan has found so far.
   typedef struct packed {
      logic                reg_hit;
      logic [IDX_W-1:0]    reg_hit_idx;
      logic                reg_free;
      logic [IDX_W-1:0]    reg_free_idx;
      logic                inf_hit;
      logic [IDX_W-1:0]    inf_hit_idx;
      logic                inf_free;
      logic [IDX_W-1:0]    inf_free_idx;
      logic [CREDIT_W-1:0] inf_cnt;
   } scan_type;

endpackage

// ----- rtl/itct_alu.sv -----
// Shared arithmetic unit of the credit tracker: clamped add, saturating
// subtract and saturating increment on 16-bit counts. Uses itct_pkg.
module itct_alu (
   input  itct_pkg::alu_req_type             req,
   output logic [itct_pkg::CREDIT_W-1:0]     result
);

   logic [itct_pkg::CREDIT_W:0] sum;

   // One wide add feeds the clamp; subtract and increment share the output mux.
   always_comb begin
      sum    = {1'b0, req.a} + {1'b0, req.b};
      result = req.a;
      case (req.op)
         itct_pkg::ALU_ADD_CLAMP: begin
            if (sum > {1'b0, req.limit}) begin
               result = req.limit;
            end else begin
               result = sum[itct_pkg::CREDIT_W-1:0];
            end
         end
         itct_pkg::ALU_SUB_SAT: begin
            if (req.a >= req.b) begin
               result = req.a - req.b;
            end else begin
               result = '0;
            end
         end
         itct_pkg::ALU_INC_SAT: begin
            if (req.a != {itct_pkg::CREDIT_W{1'b1}}) begin
               result = req.a + itct_pkg::CREDIT_W'(1);
            end
         end
         default: begin
            result = req.a;
         end
      endcase
   end

endmodule

// ----- rtl/iso_tx_credit_tracker.sv -----
// Top level of the isochronous transmit credit tracker. Uses itct_pkg and itct_alu.
// An accepted command passes the S_SCAN, S_CREDIT and S_COUNT states; S_COUNT registers the result strobe.
// No new command is taken until the block is back in idle; a sixteen-entry scan of the handle and
// in-flight tables, one entry per cycle, comes first, then the S_CREDIT and S_COUNT steps on the ALU.
// The receiver cannot stall; the result strobe lasts one cycle.
// Synchronous reset clears credit, total, all valid bits and the sequencer.
module iso_tx_credit_tracker (
   input  logic        clock,
   input  logic        reset,
   // Command channel.
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_link_handle,
   input  logic [1:0]  req_pb_flag,
   input  logic        req_ts_flag,
   input  logic [15:0] req_payload_length,
   input  logic [15:0] req_completed_count,
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_total_credits,
   // Result channel.
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_credits_available,
   output logic [31:0] rsp_header_word
);

   localparam int NL = itct_pkg::MAX_LINKS;
   localparam int IW = itct_pkg::IDX_W;
   localparam int HW = itct_pkg::HANDLE_W;
   localparam int CW = itct_pkg::CREDIT_W;

   // Sequencer and control state.
   itct_pkg::state_type  state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   itct_pkg::scan_type   scan_ff, scan_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CW-1:0]        credit_ff, credit_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Latched command beat.
   itct_pkg::cmd_type    cmd_ff, cmd_in;
   logic [HW-1:0]        handle_ff, handle_in;
   logic [1:0]           pb_ff, pb_in;
   logic                 ts_ff, ts_in;
   logic [15:0]          len_ff, len_in;
   logic [15:0]          done_ff, done_in;

   // Per-command results before they are shown.
   itct_pkg::status_type status_ff, status_in;
   logic [31:0]          header_ff, header_in;
   logic                 send_ok_ff, send_ok_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [CW-1:0]        rsp_credit_ff, rsp_credit_in;
   logic [31:0]          rsp_header_ff, rsp_header_in;

   // Tables.
   logic [NL-1:0]        reg_valid_ff;
   logic [HW-1:0]        reg_id_ff [NL];
   logic [NL-1:0]        inf_valid_ff;
   logic [HW-1:0]        inf_id_ff [NL];
   logic [CW-1:0]        inf_cnt_ff [NL];

   // Table write controls.
   logic                 reg_set, reg_clr;
   logic [IW-1:0]        reg_widx;
   logic                 inf_set, inf_clr, inf_cnt_we;
   logic [IW-1:0]        inf_widx;
   logic [CW-1:0]        inf_wcnt;

   // Shared arithmetic unit.
   itct_pkg::alu_req_type alu_req;
   logic [CW-1:0]         alu_res;

   itct_alu u_alu (
      .req    (alu_req),
      .result (alu_res)
   );

   assign busy                  = (state_ff != itct_pkg::S_IDLE);
   assign csr_ready             = (state_ff == itct_pkg::S_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_credits_available = rsp_credit_ff;
   assign rsp_header_word       = rsp_header_ff;

   // Next state, scan bookkeeping and command execution.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      total_in      = total_ff;
      credit_in     = credit_ff;
      rsp_valid_in  = 1'b0;
      cmd_in        = cmd_ff;
      handle_in     = handle_ff;
      pb_in         = pb_ff;
      ts_in         = ts_ff;
      len_in        = len_ff;
      done_in       = done_ff;
      status_in     = status_ff;
      header_in     = header_ff;
      send_ok_in    = send_ok_ff;
      rsp_status_in = rsp_status_ff;
      rsp_credit_in = rsp_credit_ff;
      rsp_header_in = rsp_header_ff;
      reg_set       = 1'b0;
      reg_clr       = 1'b0;
      reg_widx      = '0;
      inf_set       = 1'b0;
      inf_clr       = 1'b0;
      inf_cnt_we    = 1'b0;
      inf_widx      = '0;
      inf_wcnt      = '0;
      alu_req.op    = itct_pkg::ALU_ADD_CLAMP;
      alu_req.a     = credit_ff;
      alu_req.b     = '0;
      alu_req.limit = total_ff;

      case (state_ff)
         itct_pkg::S_IDLE: begin
            // A configuration beat reloads the credit along with the total.
            if (csr_valid) begin
               total_in  = csr_total_credits;
               credit_in = csr_total_credits;
            end
            if (start) begin
               cmd_in     = itct_pkg::cmd_type'(req_cmd);
               handle_in  = req_link_handle;
               pb_in      = req_pb_flag;
               ts_in      = req_ts_flag;
               len_in     = req_payload_length;
               done_in    = req_completed_count;
               scan_in    = '0;
               idx_in     = '0;
               status_in  = itct_pkg::STAT_OK;
               header_in  = '0;
               send_ok_in = 1'b0;
               state_in   = itct_pkg::S_SCAN;
            end
         end

         itct_pkg::S_SCAN: begin
            // Look at one entry of each table; keep the first hit and first free slot.
            if (!scan_ff.reg_hit && reg_valid_ff[idx_ff] && reg_id_ff[idx_ff] == handle_ff) begin
               scan_in.reg_hit     = 1'b1;
               scan_in.reg_hit_idx = idx_ff;
            end
            if (!scan_ff.reg_free && !reg_valid_ff[idx_ff]) begin
               scan_in.reg_free     = 1'b1;
               scan_in.reg_free_idx = idx_ff;
            end
            if (!scan_ff.inf_hit && inf_valid_ff[idx_ff] && inf_id_ff[idx_ff] == handle_ff) begin
               scan_in.inf_hit     = 1'b1;
               scan_in.inf_hit_idx = idx_ff;
               scan_in.inf_cnt     = inf_cnt_ff[idx_ff];
            end
            if (!scan_ff.inf_free && !inf_valid_ff[idx_ff]) begin
               scan_in.inf_free     = 1'b1;
               scan_in.inf_free_idx = idx_ff;
            end
            idx_in = idx_ff + IW'(1);
            if (idx_ff == IW'(NL - 1)) begin
               state_in = itct_pkg::S_CREDIT;
            end
         end

         itct_pkg::S_CREDIT: begin
            // Handle set updates and the credit side of each command.
            case (cmd_ff)
               itct_pkg::CMD_REGISTER: begin
                  if (!scan_ff.reg_hit) begin
                     if (scan_ff.reg_free) begin
                        reg_set  = 1'b1;
                        reg_widx = scan_ff.reg_free_idx;
                     end else begin
                        status_in = itct_pkg::STAT_NO_ENTRY;
                     end
                  end
               end
               itct_pkg::CMD_DEREGISTER: begin
                  if (scan_ff.reg_hit) begin
                     reg_clr  = 1'b1;
                     reg_widx = scan_ff.reg_hit_idx;
                  end
                  if (scan_ff.inf_hit) begin
                     alu_req.op = itct_pkg::ALU_ADD_CLAMP;
                     alu_req.b  = scan_ff.inf_cnt;
                     credit_in  = alu_res;
                     inf_clr    = 1'b1;
                     inf_widx   = scan_ff.inf_hit_idx;
                  end
               end
               itct_pkg::CMD_SEND: begin
                  if (handle_ff > itct_pkg::HANDLE_LIMIT || len_ff > itct_pkg::MAX_LOAD) begin
                     status_in = itct_pkg::STAT_BAD_PARAM;
                  end else if (credit_ff == '0) begin
                     status_in = itct_pkg::STAT_NO_CREDIT;
                  end else if (!scan_ff.inf_hit && !scan_ff.inf_free) begin
                     status_in = itct_pkg::STAT_NO_ENTRY;
                  end else begin
                     alu_req.op = itct_pkg::ALU_SUB_SAT;
                     alu_req.b  = CW'(1);
                     credit_in  = alu_res;
                     send_ok_in = 1'b1;
                     header_in  = {2'b00, len_ff[13:0], 1'b0, ts_ff, pb_ff, handle_ff};
                  end
               end
               itct_pkg::CMD_COMPLETE: begin
                  if (scan_ff.reg_hit) begin
                     alu_req.op = itct_pkg::ALU_ADD_CLAMP;
                     alu_req.b  = done_ff;
                     credit_in  = alu_res;
                  end
               end
               default: begin
                  status_in = status_ff;
               end
            endcase
            state_in = itct_pkg::S_COUNT;
         end

         itct_pkg::S_COUNT: begin
            // In-flight count update, then the result beat.
            if (cmd_ff == itct_pkg::CMD_SEND && send_ok_ff) begin
               alu_req.op = itct_pkg::ALU_INC_SAT;
               alu_req.a  = scan_ff.inf_hit ? scan_ff.inf_cnt : '0;
               inf_set    = 1'b1;
               inf_widx   = scan_ff.inf_hit ? scan_ff.inf_hit_idx : scan_ff.inf_free_idx;
               inf_wcnt   = alu_res;
            end else if (cmd_ff == itct_pkg::CMD_COMPLETE && scan_ff.reg_hit
                         && scan_ff.inf_hit) begin
               alu_req.op = itct_pkg::ALU_SUB_SAT;
               alu_req.a  = scan_ff.inf_cnt;
               alu_req.b  = done_ff;
               inf_cnt_we = 1'b1;
               inf_widx   = scan_ff.inf_hit_idx;
               inf_wcnt   = alu_res;
            end
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_credit_in = credit_ff;
            rsp_header_in = header_ff;
            state_in      = itct_pkg::S_IDLE;
         end

         default: begin
            state_in = itct_pkg::S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itct_pkg::S_IDLE;
         total_ff     <= '0;
         credit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         reg_valid_ff <= '0;
         inf_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         credit_ff    <= credit_in;
         rsp_valid_ff <= rsp_valid_in;
         if (reg_set) begin
            reg_valid_ff[reg_widx] <= 1'b1;
         end else if (reg_clr) begin
            reg_valid_ff[reg_widx] <= 1'b0;
         end
         if (inf_set) begin
            inf_valid_ff[inf_widx] <= 1'b1;
         end else if (inf_clr) begin
            inf_valid_ff[inf_widx] <= 1'b0;
         end
      end
   end

   // Payload registers and table contents.
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      cmd_ff        <= cmd_in;
      handle_ff     <= handle_in;
      pb_ff         <= pb_in;
      ts_ff         <= ts_in;
      len_ff        <= len_in;
      done_ff       <= done_in;
      status_ff     <= status_in;
      header_ff     <= header_in;
      send_ok_ff    <= send_ok_in;
      rsp_status_ff <= rsp_status_in;
      rsp_credit_ff <= rsp_credit_in;
      rsp_header_ff <= rsp_header_in;
      if (reg_set) begin
         reg_id_ff[reg_widx] <= handle_ff;
      end
      if (inf_set) begin
         inf_id_ff[inf_widx] <= handle_ff;
      end
      if (inf_set || inf_cnt_we) begin
         inf_cnt_ff[inf_widx] <= inf_wcnt;
      end
   end

endmodule

// ----- rtl/itct_checker.sv -----
// Port-level checks for the isochronous transmit credit tracker, and the bind
// that attaches them to iso_tx_credit_tracker. Uses itct_pkg for the status codes.
module itct_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_header_word
);

   // An accepted command keeps the block busy on the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not make the block busy");

   // Each result beat stands alone; commands never produce two in a row.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for more than one cycle");

   // The result beat comes out as the block returns to idle.
   a_beat_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result beat while still busy");

   // A header is produced only by a successful send.
   a_header_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != itct_pkg::STAT_OK) |-> (rsp_header_word == 32'd0))
      else $error("nonzero header with failing status");

endmodule

bind iso_tx_credit_tracker itct_checker u_itct_checker (.*);

// ----- bench/iso_tx_credit_tracker_chk.sv -----
`timescale 1ns / 1ps
// Scoreboard for iso_tx_credit_tracker: watches the command, configuration and result channels.
// It keeps its own credit and handle tables and checks every result beat against them.
// Depends on itct_pkg for the command and status codes and the table limits.
module iso_tx_credit_tracker_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [11:0] req_link_handle,
   input  logic [1:0]  req_pb_flag,
   input  logic        req_ts_flag,
   input  logic [15:0] req_payload_length,
   input  logic [15:0] req_completed_count,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [15:0] csr_total_credits,
   input  logic        rsp_valid,
   input  logic [1:0]  rsp_status,
   input  logic [15:0] rsp_credits_available,
   input  logic [31:0] rsp_header_word,
   output int          mismatches,
   output int          pending
);

   localparam int LINKS = itct_pkg::MAX_LINKS;

   // One predicted result beat.
   typedef struct packed {
      itct_pkg::status_type status;
      logic [15:0]          credits;
      logic [31:0]          header;
   } credit_result_type;

   credit_result_type credit_results[$];

   // Shadow copy of the block's configuration and tables.
   logic [15:0] total_credits;
   logic [15:0] credit_now;
   logic        link_valid   [LINKS];
   logic [11:0] link_id      [LINKS];
   logic        flight_valid [LINKS];
   logic [11:0] flight_id    [LINKS];
   logic [15:0] flight_count [LINKS];

   function automatic int find_link(input logic [11:0] h);
      for (int i = 0; i < LINKS; i++)
         if (link_valid[i] && link_id[i] == h) return i;
      return -1;
   endfunction

   function automatic int find_flight(input logic [11:0] h);
      for (int i = 0; i < LINKS; i++)
         if (flight_valid[i] && flight_id[i] == h) return i;
      return -1;
   endfunction

   // Credit after adding an amount back, never above the configured total.
   function automatic logic [15:0] refilled(input logic [15:0] amount);
      logic [16:0] sum;
      sum = {1'b0, credit_now} + {1'b0, amount};
      return (sum > {1'b0, total_credits}) ? total_credits : sum[15:0];
   endfunction

   // Applies one command to the shadow tables and queues the result it gives.
   task automatic predict_command(input itct_pkg::cmd_type c, input logic [11:0] h,
                                  input logic [1:0] pb, input logic ts,
                                  input logic [15:0] len, input logic [15:0] done);
      credit_result_type res;
      int r;
      int t;
      res.status = itct_pkg::STAT_OK;
      res.header = '0;
      case (c)
         itct_pkg::CMD_REGISTER: begin
            // A handle already present is left alone; a full set refuses a new one.
            if (find_link(h) < 0) begin
               r = -1;
               for (int i = LINKS - 1; i >= 0; i--)
                  if (!link_valid[i]) r = i;
               if (r < 0) begin
                  res.status = itct_pkg::STAT_NO_ENTRY;
               end else begin
                  link_valid[r] = 1'b1;
                  link_id[r]    = h;
               end
            end
         end
         itct_pkg::CMD_DEREGISTER: begin
            // Credit comes back only when the handle has packets tracked.
            r = find_link(h);
            if (r >= 0) link_valid[r] = 1'b0;
            t = find_flight(h);
            if (t >= 0) begin
               credit_now      = refilled(flight_count[t]);
               flight_valid[t] = 1'b0;
            end
         end
         itct_pkg::CMD_SEND: begin
            if (h > itct_pkg::HANDLE_LIMIT || len > itct_pkg::MAX_LOAD) begin
               res.status = itct_pkg::STAT_BAD_PARAM;
            end else if (credit_now == 16'd0) begin
               res.status = itct_pkg::STAT_NO_CREDIT;
            end else begin
               // Unregistered handles are tracked too; take the lowest free entry.
               t = find_flight(h);
               if (t < 0) begin
                  for (int i = LINKS - 1; i >= 0; i--)
                     if (!flight_valid[i]) t = i;
                  if (t >= 0) begin
                     flight_valid[t] = 1'b1;
                     flight_id[t]    = h;
                     flight_count[t] = 16'd0;
                  end
               end
               if (t < 0) begin
                  res.status = itct_pkg::STAT_NO_ENTRY;
               end else begin
                  credit_now = credit_now - 16'd1;
                  if (flight_count[t] != 16'hFFFF) flight_count[t] = flight_count[t] + 16'd1;
                  res.header = {2'b00, len[13:0], 1'b0, ts, pb, h};
               end
            end
         end
         default: begin
            // Completion counts only for registered handles; the count floors at zero.
            if (find_link(h) >= 0) begin
               credit_now = refilled(done);
               t = find_flight(h);
               if (t >= 0)
                  flight_count[t] = (flight_count[t] >= done) ? flight_count[t] - done : 16'd0;
            end
         end
      endcase
      res.credits = credit_now;
      credit_results.push_back(res);
   endtask

   always @(posedge clock) begin : watch
      credit_result_type oldest;
      if (reset) begin
         total_credits = '0;
         credit_now    = '0;
         for (int i = 0; i < LINKS; i++) begin
            link_valid[i]   = 1'b0;
            flight_valid[i] = 1'b0;
         end
         credit_results.delete();
      end else begin
         // A configuration beat sets the total and reloads the credit to it.
         if (csr_valid && csr_ready) begin
            total_credits = csr_total_credits;
            credit_now    = csr_total_credits;
         end

         // Compare a result beat with the oldest prediction.
         if (rsp_valid) begin
            if (credit_results.size() == 0) begin
               $display("%0t: result beat with nothing expected: status %0d credits %0d header %h",
                        $time, rsp_status, rsp_credits_available, rsp_header_word);
               mismatches++;
            end else begin
               oldest = credit_results.pop_front();
               if (rsp_status !== oldest.status) begin
                  $display("%0t: status expected %0d, actual %0d",
                           $time, oldest.status, rsp_status);
                  mismatches++;
               end
               if (rsp_credits_available !== oldest.credits) begin
                  $display("%0t: credits_available expected %0d, actual %0d",
                           $time, oldest.credits, rsp_credits_available);
                  mismatches++;
               end
               if (rsp_header_word !== oldest.header) begin
                  $display("%0t: header_word expected %h, actual %h",
                           $time, oldest.header, rsp_header_word);
                  mismatches++;
               end
            end
         end

         // An accepted command beat.
         if (start && !busy)
            predict_command(itct_pkg::cmd_type'(req_cmd), req_link_handle, req_pb_flag,
                            req_ts_flag, req_payload_length, req_completed_count);
      end
      pending = credit_results.size();
   end

endmodule

// ----- bench/iso_tx_credit_tracker_tb.sv -----
`timescale 1ns / 1ps
// Testbench top for iso_tx_credit_tracker: clock, reset, command and configuration stimulus.
// Depends on itct_pkg, the block and iso_tx_credit_tracker_chk, which does the scoreboard checking.
module iso_tx_credit_tracker_tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 9;
   localparam int PHASE_ITEMS = 100;
   localparam int POOL_MAX    = 24;
   localparam int SETTLE      = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [11:0] req_link_handle;
   logic [1:0]  req_pb_flag;
   logic        req_ts_flag;
   logic [15:0] req_payload_length;
   logic [15:0] req_completed_count;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_total_credits;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_credits_available;
   logic [31:0] rsp_header_word;

   int          mismatches;
   int          pending;
   int          cycles = 0;
   logic [11:0] handle_pool [POOL_MAX];
   int          pool_size;

   always #6 clock = ~clock;

   iso_tx_credit_tracker DUT (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_link_handle       (req_link_handle),
      .req_pb_flag           (req_pb_flag),
      .req_ts_flag           (req_ts_flag),
      .req_payload_length    (req_payload_length),
      .req_completed_count   (req_completed_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_total_credits     (csr_total_credits),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_credits_available (rsp_credits_available),
      .rsp_header_word       (rsp_header_word)
   );

   iso_tx_credit_tracker_chk credit_chk (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_cmd               (req_cmd),
      .req_link_handle       (req_link_handle),
      .req_pb_flag           (req_pb_flag),
      .req_ts_flag           (req_ts_flag),
      .req_payload_length    (req_payload_length),
      .req_completed_count   (req_completed_count),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_total_credits     (csr_total_credits),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_credits_available (rsp_credits_available),
      .rsp_header_word       (rsp_header_word),
      .mismatches            (mismatches),
      .pending               (pending)
   );

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Drives one command beat and holds it until the block takes it.
   task automatic issue_command(input itct_pkg::cmd_type c, input logic [11:0] h,
                                input logic [1:0] pb, input logic ts,
                                input logic [15:0] len, input logic [15:0] cnt);
      req_cmd             <= c;
      req_link_handle     <= h;
      req_pb_flag         <= pb;
      req_ts_flag         <= ts;
      req_payload_length  <= len;
      req_completed_count <= cnt;
      start               <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Stops sending until every predicted result has arrived and the block is free.
   task automatic wait_idle();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
      while (busy) @(posedge clock);
   endtask

   // Writes the credit total while the block is idle.
   task automatic load_total(input logic [15:0] value);
      wait_idle();
      csr_total_credits <= value;
      csr_valid         <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // One random command: mostly pooled handles so the tables fill, some noise.
   task automatic random_command(input int dereg_pct);
      itct_pkg::cmd_type c;
      logic [11:0]       h;
      logic [15:0]       len;
      logic [15:0]       cnt;
      int                pick;
      pick = int'($urandom_range(0, 99));
      if (pick < 25)                  c = itct_pkg::CMD_REGISTER;
      else if (pick < 25 + dereg_pct) c = itct_pkg::CMD_DEREGISTER;
      else if (pick < 70)             c = itct_pkg::CMD_SEND;
      else                            c = itct_pkg::CMD_COMPLETE;
      if ($urandom_range(0, 9) == 0) h = 12'($urandom);
      else                           h = handle_pool[$urandom_range(0, pool_size - 1)];
      if ($urandom_range(0, 6) == 0) len = 16'($urandom);
      else                           len = 16'($urandom_range(0, itct_pkg::MAX_LOAD));
      case ($urandom_range(0, 9))
         0:       cnt = 16'($urandom);
         1:       cnt = 16'hFFFF;
         default: cnt = 16'($urandom_range(0, 3));
      endcase
      issue_command(c, h, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), len, cnt);
   endtask

   initial begin : stimulus
      logic [15:0] phase_total [PHASES];
      int          dereg_pct;
      start               = 1'b0;
      req_cmd             = '0;
      req_link_handle     = '0;
      req_pb_flag         = '0;
      req_ts_flag         = 1'b0;
      req_payload_length  = '0;
      req_completed_count = '0;
      csr_valid           = 1'b0;
      csr_total_credits   = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Out of reset the credit is zero, so a send is refused.
      issue_command(itct_pkg::CMD_SEND, 12'h001, 2'd0, 1'b0, 16'd10, 16'd0);
      load_total(16'd4);
      // Register twice, then a handle above the send limit.
      issue_command(itct_pkg::CMD_REGISTER, 12'h000, 2'd0, 1'b0, 16'd0, 16'd0);
      issue_command(itct_pkg::CMD_REGISTER, 12'h000, 2'd0, 1'b0, 16'd0, 16'd0);
      issue_command(itct_pkg::CMD_REGISTER, 12'hFFF, 2'd3, 1'b1, 16'hFFFF, 16'hFFFF);
      // Bad handle, bad length, then the largest legal length and a flag-free send.
      issue_command(itct_pkg::CMD_SEND, 12'hF00, 2'd1, 1'b0, 16'd1, 16'd0);
      issue_command(itct_pkg::CMD_SEND, 12'h000, 2'd1, 1'b0, 16'd16384, 16'd0);
      issue_command(itct_pkg::CMD_SEND, 12'h000, 2'd3, 1'b1, 16'd16383, 16'd0);
      issue_command(itct_pkg::CMD_SEND, 12'hEFF, 2'd0, 1'b0, 16'd0, 16'd0);
      // Oversized completion, completion on an unregistered handle, and on one untracked.
      issue_command(itct_pkg::CMD_COMPLETE, 12'h000, 2'd0, 1'b0, 16'd0, 16'hFFFF);
      issue_command(itct_pkg::CMD_COMPLETE, 12'hEFF, 2'd0, 1'b0, 16'd0, 16'd1);
      issue_command(itct_pkg::CMD_COMPLETE, 12'hFFF, 2'd0, 1'b0, 16'd0, 16'd2);
      // Deregister a tracked but unregistered handle, an unknown one, and a known one.
      issue_command(itct_pkg::CMD_DEREGISTER, 12'hEFF, 2'd0, 1'b0, 16'd0, 16'd0);
      issue_command(itct_pkg::CMD_DEREGISTER, 12'h123, 2'd0, 1'b0, 16'd0, 16'd0);
      issue_command(itct_pkg::CMD_DEREGISTER, 12'h000, 2'd0, 1'b0, 16'd0, 16'd0);
      // Alternating bit patterns in the length, pb flag and count fields.
      issue_command(itct_pkg::CMD_SEND, 12'hABC, 2'd1, 1'b0, 16'h2AAA, 16'hAAAA);
      issue_command(itct_pkg::CMD_SEND, 12'h543, 2'd2, 1'b1, 16'h1555, 16'h5555);
      // Fill the handle set and go past it.
      for (int i = 1; i <= 16; i++)
         issue_command(itct_pkg::CMD_REGISTER, 12'(12'h100 + i), 2'd0, 1'b0, 16'd0, 16'd0);

      // Random phases, each under its own credit total.
      phase_total = '{16'hFFFF, 16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'hFFFE, 16'd0, 16'd0};
      phase_total[4] = 16'($urandom);
      phase_total[7] = 16'($urandom_range(5, 60));
      for (int p = 0; p < PHASES; p++) begin
         load_total(phase_total[p]);
         // The first phase uses many legal handles and rare deregisters to fill the tables.
         pool_size = (p == 0) ? POOL_MAX : int'($urandom_range(6, POOL_MAX));
         for (int i = 0; i < pool_size; i++)
            handle_pool[i] = (p == 0 || $urandom_range(0, 4) != 0) ?
                             12'($urandom_range(0, 12'hEFF)) :
                             12'($urandom_range(12'hF00, 12'hFFF));
         dereg_pct = (p == 0) ? 2 : int'($urandom_range(5, 20));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ((p == 1 && n == 50) || $urandom_range(0, 99) == 0) begin
               wait_idle();
            end else if (p != 3 && $urandom_range(0, 99) < 20) begin
               // The fourth phase runs back to back; elsewhere the sender pauses at random.
               start <= 1'b0;
               repeat ($urandom_range(1, 30)) @(posedge clock);
            end
            random_command(dereg_pct);
         end
      end

      // Drain and let any stray result beat show up.
      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
